// ===== src/ttc_pkg.sv =====
// ttc_pkg: shared types, codes and constants for the tick/time converter
// used by ttc_front, ttc_div_cell and tick_time_converter; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ttc_pkg;

    localparam int CNT_W     = 32;              // counter and result width
    localparam int CFG_W     = 23;              // widest config register
    localparam int DEN_W     = 23;              // divisor / multiplier width
    localparam int NS_SHIFT  = 10;              // 1024 ns unit
    localparam int DIV_STEPS = CNT_W;           // one quotient bit per cell
    localparam int LATENCY   = DIV_STEPS + 3;   // start to done, in cycles
    localparam int PROD_W    = CNT_W + DEN_W;
    localparam int CMP_W     = PROD_W + 1;

    typedef enum logic [1:0] {
        CMD_MEASURE = 2'd0,
        CMD_CONVERT = 2'd1,
        CMD_TIMEOUT = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        UNIT_1024NS = 2'd0,
        UNIT_US     = 2'd1,
        UNIT_MS     = 2'd2
    } unit_t;

    typedef enum logic [2:0] {
        REG_COUNT_UP     = 3'd0,
        REG_CEIL_1024NS  = 3'd1,
        REG_CEIL_US      = 3'd2,
        REG_CEIL_MS      = 3'd3,
        REG_FLOOR_1024NS = 3'd4,
        REG_FLOOR_US     = 3'd5,
        REG_FLOOR_MS     = 3'd6
    } reg_idx_t;

    // one word moving down the divider chain
    typedef struct packed {
        logic [DEN_W-1:0] den;
        logic [DEN_W-1:0] rem;
        logic [CNT_W-1:0] word;   // dividend bits shift out, quotient bits shift in
    } div_t;

    // everything besides the quotient that a word needs at the output
    typedef struct packed {
        logic             valid;
        logic             use_div;
        logic             shift10;
        logic             dz;
        logic             tmo;
        logic             rerr;
        logic [CNT_W-1:0] alt;
    } side_t;

endpackage

`default_nettype wire

// ===== src/ttc_div_cell.sv =====
// ttc_div_cell: one restoring division step, registered
// depends on ttc_pkg
`timescale 1ns / 1ps
`default_nettype none

module ttc_div_cell
(
    input  wire logic          clk,
    input  wire ttc_pkg::div_t prev,
    output ttc_pkg::div_t      cur
);

    ttc_pkg::div_t            cur_reg;
    ttc_pkg::div_t            cur_next;
    logic [ttc_pkg::DEN_W:0]  trial;
    logic [ttc_pkg::DEN_W:0]  trial_sub;
    logic                     fits;

    always_comb
    begin
        trial     = {prev.rem, prev.word[ttc_pkg::CNT_W-1]};
        trial_sub = trial - {1'b0, prev.den};
        fits      = (trial >= {1'b0, prev.den});
        cur_next.den  = prev.den;
        // remainder stays below the divisor, so the top bit drops out
        cur_next.rem  = fits ? trial_sub[ttc_pkg::DEN_W-1:0] : trial[ttc_pkg::DEN_W-1:0];
        cur_next.word = {prev.word[ttc_pkg::CNT_W-2:0], fits};
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    assign cur = cur_reg;

endmodule

`default_nettype wire

// ===== src/ttc_front.sv =====
// ttc_front: config registers, elapsed count, dividend, product and range check
// depends on ttc_pkg; feeds the divider chain and the side line in the top level
`timescale 1ns / 1ps
`default_nettype none

module ttc_front
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_write,
    input  wire logic [2:0]                 cfg_index,
    input  wire logic [ttc_pkg::CFG_W-1:0]  cfg_data,
    input  wire logic                       accept,
    input  wire logic [1:0]                 command,
    input  wire logic [1:0]                 unit,
    input  wire logic [ttc_pkg::CNT_W-1:0]  first_count,
    input  wire logic [ttc_pkg::CNT_W-1:0]  second_count,
    input  wire logic [ttc_pkg::CNT_W-1:0]  amount,
    output ttc_pkg::div_t                   div_out,
    output ttc_pkg::side_t                  side_out
);

    localparam int CW = ttc_pkg::CNT_W;
    localparam int DW = ttc_pkg::DEN_W;

    // config
    logic          count_up_reg;
    logic [DW-1:0] ceil_ns_reg, ceil_us_reg, ceil_ms_reg;
    logic [DW-1:0] floor_ns_reg, floor_us_reg, floor_ms_reg;

    // stage 1
    logic          v1_reg;
    logic [1:0]    cmd1_reg, unit1_reg;
    logic [CW-1:0] diff1_reg, diff1_next;
    logic [CW-1:0] amount1_reg;

    // stage 2
    logic                        v2_reg;
    logic                        use_div2_reg, use_div2_next;
    logic                        shift2_reg, shift2_next;
    logic                        dz2_reg, dz2_next;
    logic                        tmo2_reg, tmo2_next;
    logic                        conv2_reg, conv2_next;
    logic                        ns2_reg, ns2_next;
    logic [CW-1:0]               alt2_reg, alt2_next;
    logic [CW-1:0]               num2_reg, num2_next;
    logic [DW-1:0]               den2_reg, den2_next;
    logic [DW-1:0]               c2_reg, c2_next;
    logic [ttc_pkg::PROD_W-1:0]  prod2_reg, prod2_next;

    logic                        unit_ok;
    logic                        ns_high;
    logic [CW-1:0]               num_base;
    logic [CW-1:0]               round_sum;
    logic [ttc_pkg::CMP_W-1:0]   prod_plus_c;
    logic [ttc_pkg::CMP_W-1:0]   range_limit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_up_reg <= 1'b0;
            ceil_ns_reg  <= DW'(103);
            ceil_us_reg  <= DW'(100);
            ceil_ms_reg  <= DW'(100000);
            floor_ns_reg <= DW'(102);
            floor_us_reg <= DW'(100);
            floor_ms_reg <= DW'(100000);
        end
        else if (cfg_write)
        begin
            unique case (ttc_pkg::reg_idx_t'(cfg_index))
                ttc_pkg::REG_COUNT_UP:     count_up_reg <= cfg_data[0];
                ttc_pkg::REG_CEIL_1024NS:  ceil_ns_reg  <= {7'd0, cfg_data[15:0]};
                ttc_pkg::REG_CEIL_US:      ceil_us_reg  <= {7'd0, cfg_data[15:0]};
                ttc_pkg::REG_CEIL_MS:      ceil_ms_reg  <= cfg_data;
                ttc_pkg::REG_FLOOR_1024NS: floor_ns_reg <= {7'd0, cfg_data[15:0]};
                ttc_pkg::REG_FLOOR_US:     floor_us_reg <= {7'd0, cfg_data[15:0]};
                ttc_pkg::REG_FLOOR_MS:     floor_ms_reg <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // stage 1: wrapped elapsed count
    always_comb
    begin
        if (count_up_reg)
            diff1_next = second_count - first_count;
        else
            diff1_next = first_count - second_count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd1_reg    <= command;
        unit1_reg   <= unit;
        diff1_reg   <= diff1_next;
        amount1_reg <= amount;
    end

    // stage 2: operand selection, dividend, product
    always_comb
    begin
        unit_ok   = 1'b1;
        den2_next = '0;
        c2_next   = '0;
        case (unit1_reg)
            ttc_pkg::UNIT_1024NS:
            begin
                den2_next = floor_ns_reg;
                c2_next   = ceil_ns_reg;
            end
            ttc_pkg::UNIT_US:
            begin
                den2_next = floor_us_reg;
                c2_next   = ceil_us_reg;
            end
            ttc_pkg::UNIT_MS:
            begin
                den2_next = floor_ms_reg;
                c2_next   = ceil_ms_reg;
            end
            default: unit_ok = 1'b0;
        endcase

        ns2_next = (unit1_reg == ttc_pkg::UNIT_1024NS);
        ns_high  = (diff1_reg[CW-1:CW-ttc_pkg::NS_SHIFT] != '0);
        // small 1024 ns differences are scaled before the divide, large ones after
        if (ns2_next && !ns_high)
            num_base = {diff1_reg[CW-ttc_pkg::NS_SHIFT-1:0], {ttc_pkg::NS_SHIFT{1'b0}}};
        else
            num_base = diff1_reg;
        num2_next   = num_base + CW'(den2_next) - CW'(1);
        prod2_next  = ttc_pkg::PROD_W'(c2_next) * ttc_pkg::PROD_W'(amount1_reg);
        shift2_next = ns2_next && ns_high;

        use_div2_next = 1'b0;
        dz2_next      = 1'b0;
        tmo2_next     = 1'b0;
        conv2_next    = 1'b0;
        alt2_next     = '0;
        case (cmd1_reg)
            ttc_pkg::CMD_MEASURE:
            begin
                if (unit_ok)
                begin
                    if (den2_next == '0)
                    begin
                        dz2_next  = 1'b1;
                        alt2_next = '1;
                    end
                    else
                        use_div2_next = 1'b1;
                end
            end
            ttc_pkg::CMD_CONVERT:
            begin
                conv2_next = unit_ok;
            end
            ttc_pkg::CMD_TIMEOUT:
            begin
                if (unit_ok)
                begin
                    alt2_next = diff1_reg;
                    tmo2_next = (diff1_reg >= amount1_reg);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        use_div2_reg <= use_div2_next;
        shift2_reg   <= shift2_next;
        dz2_reg      <= dz2_next;
        tmo2_reg     <= tmo2_next;
        conv2_reg    <= conv2_next;
        ns2_reg      <= ns2_next;
        alt2_reg     <= alt2_next;
        num2_reg     <= num2_next;
        den2_reg     <= den2_next;
        c2_reg       <= c2_next;
        prod2_reg    <= prod2_next;
    end

    // amount >= floor(lim / c) is the same as amount * c + c > lim
    always_comb
    begin
        round_sum   = prod2_reg[CW-1:0] + CW'(1023);
        prod_plus_c = {1'b0, prod2_reg} + ttc_pkg::CMP_W'(c2_reg);
        if (ns2_reg)
            range_limit = ttc_pkg::CMP_W'({CW{1'b1}}) - ttc_pkg::CMP_W'(1023);
        else
            range_limit = ttc_pkg::CMP_W'({CW{1'b1}});

        side_out.valid   = v2_reg;
        side_out.use_div = use_div2_reg;
        side_out.shift10 = shift2_reg;
        side_out.dz      = dz2_reg;
        side_out.tmo     = tmo2_reg;
        side_out.rerr    = conv2_reg && (prod_plus_c > range_limit);
        if (conv2_reg)
            side_out.alt = ns2_reg ? (round_sum >> ttc_pkg::NS_SHIFT) : prod2_reg[CW-1:0];
        else
            side_out.alt = alt2_reg;

        div_out.den  = den2_reg;
        div_out.rem  = '0;
        div_out.word = num2_reg;
    end

endmodule

`default_nettype wire

// ===== src/tick_time_converter.sv =====
// tick_time_converter: top level, divider cell chain, side line and output register
// depends on ttc_pkg, ttc_front, ttc_div_cell
`timescale 1ns / 1ps
`default_nettype none

// Takes one command word in every clock cycle (busy is always low) and gives its
// result on value and the flags, marked by done. Each word passes the stage
// register for the elapsed count, the one for dividend and product, the
// divider, which is a chain of 32 cells each settling one quotient bit, and
// the output register. Results come out in order, one per cycle at most, and
// the receiver must take each in the cycle it appears.
// Config writes take effect at once and belong in idle periods.
module tick_time_converter
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_write,
    input  wire logic [2:0]                 cfg_index,
    input  wire logic [ttc_pkg::CFG_W-1:0]  cfg_data,
    input  wire logic                       start,
    output      logic                       busy,
    input  wire logic [1:0]                 command,
    input  wire logic [1:0]                 unit,
    input  wire logic [ttc_pkg::CNT_W-1:0]  first_count,
    input  wire logic [ttc_pkg::CNT_W-1:0]  second_count,
    input  wire logic [ttc_pkg::CNT_W-1:0]  amount,
    output      logic                       done,
    output      logic [ttc_pkg::CNT_W-1:0]  value,
    output      logic                       timed_out,
    output      logic                       range_error,
    output      logic                       divide_by_zero
);

    localparam int CW = ttc_pkg::CNT_W;
    localparam int NS = ttc_pkg::DIV_STEPS;

    ttc_pkg::div_t    chain [0:NS];
    ttc_pkg::side_t   side_in;
    ttc_pkg::side_t   side_reg [0:NS-1];
    logic [NS-1:0]    side_vld_reg;
    ttc_pkg::side_t   side_end;
    logic [CW-1:0]    quot;

    logic             done_reg;
    logic [CW-1:0]    value_reg, value_next;
    logic             tmo_reg, rerr_reg, dz_reg;

    assign busy = 1'b0;

    ttc_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .accept       (start),
        .command      (command),
        .unit         (unit),
        .first_count  (first_count),
        .second_count (second_count),
        .amount       (amount),
        .div_out      (chain[0]),
        .side_out     (side_in)
    );

    for (genvar i = 0; i < NS; i++)
    begin : g_cell
        ttc_div_cell u_cell
        (
            .clk  (clk),
            .prev (chain[i]),
            .cur  (chain[i+1])
        );
    end

    // side line runs beside the divider so every word leaves aligned with its quotient
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            side_vld_reg <= '0;
        else
            side_vld_reg <= {side_vld_reg[NS-2:0], side_in.valid};
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_in;
        for (int i = 1; i < NS; i++)
        begin
            side_reg[i] <= side_reg[i-1];
        end
    end

    always_comb
    begin
        side_end       = side_reg[NS-1];
        side_end.valid = side_vld_reg[NS-1];
        quot           = chain[NS].word;
        if (side_end.use_div)
            value_next = side_end.shift10 ? (quot << ttc_pkg::NS_SHIFT) : quot;
        else
            value_next = side_end.alt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= side_end.valid;
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        tmo_reg   <= side_end.tmo;
        rerr_reg  <= side_end.rerr;
        dz_reg    <= side_end.dz;
    end

    assign done           = done_reg;
    assign value          = value_reg;
    assign timed_out      = tmo_reg;
    assign range_error    = rerr_reg;
    assign divide_by_zero = dz_reg;

`ifndef SYNTHESIS
    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, ttc_pkg::LATENCY))
        else $error("result word without a matching start");

    a_dz_all_ones: assert property (@(posedge clk) disable iff (!rst_n)
        (done && divide_by_zero) |-> (value == {CW{1'b1}}))
        else $error("divide by zero without all-ones value");

    a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $onehot0({timed_out, range_error, divide_by_zero}))
        else $error("more than one result flag set");

    a_side_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        side_end.valid |-> !(side_end.use_div && side_end.dz))
        else $error("divide word marked both divide and divide by zero");
`endif

endmodule

`default_nettype wire
